@@ sv/oal_pkg.sv @@
// ----------------------------------------------------------------------------
// Ordered array list package
// Shared widths, command and status codes, and the operand and result
// types of the shared arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package oal_pkg;

  // Field widths of the command and response channels.
  localparam int OP_W   = 4;
  localparam int CNT_W  = 11;
  localparam int WORD_W = 32;
  localparam int ST_W   = 3;

  // Default store depth and the reset value of the capacity register.
  localparam int              DEPTH_DEFAULT = 1024;
  localparam logic [CNT_W-1:0] CAP_RESET    = 11'd1024;

  // Command codes.
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 4'd0,
    OP_INSERT = 4'd1,
    OP_DELETE = 4'd2,
    OP_GET    = 4'd3,
    OP_SET    = 4'd4,
    OP_SORTED = 4'd5,
    OP_SEARCH = 4'd6,
    OP_MAX    = 4'd7,
    OP_MIN    = 4'd8,
    OP_SUM    = 4'd9
  } op_t;

  // Response status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADIDX   = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // Operands handed to the shared unit.
  typedef struct packed {
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
  } unit_req_t;

  // Everything the shared unit works out from one pair of operands.
  typedef struct packed {
    logic                     gt;
    logic                     eq;
    logic signed [WORD_W-1:0] sum;
  } unit_res_t;

endpackage

`default_nettype wire

@@ sv/oal_if.sv @@
// ----------------------------------------------------------------------------
// Ordered array list channel interfaces
// Valid/ready command and response channels; a transfer happens at a rising
// clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface oal_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [oal_pkg::OP_W-1:0]         opcode;
  logic [oal_pkg::CNT_W-1:0]        position;
  logic signed [oal_pkg::WORD_W-1:0] operand_value;

  modport source (output valid, opcode, position, operand_value, input ready);
  modport sink   (input valid, opcode, position, operand_value, output ready);
endinterface

interface oal_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [oal_pkg::ST_W-1:0]         status;
  logic signed [oal_pkg::WORD_W-1:0] result_word;
  logic [oal_pkg::CNT_W-1:0]        element_count;

  modport source (output valid, status, result_word, element_count, input ready);
  modport sink   (input valid, status, result_word, element_count, output ready);
endinterface

`default_nettype wire

@@ sv/oal_store.sv @@
// ----------------------------------------------------------------------------
// Ordered array list element store
// Simple dual-port memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oal_store #(
  parameter int DEPTH = oal_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [AW-1:0]                 waddr,
  input  wire logic [oal_pkg::WORD_W-1:0]    wdata,
  input  wire logic                          re,
  input  wire logic [AW-1:0]                 raddr,
  output logic      [oal_pkg::WORD_W-1:0]    rdata
);
  import oal_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ sv/oal_unit.sv @@
// ----------------------------------------------------------------------------
// Ordered array list shared unit
// One signed compare, one equality check and one wrapping adder, used by the
// walks of sorted insert, search, max, min and sum over the stored words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oal_unit (
  input  wire oal_pkg::unit_req_t req,
  output oal_pkg::unit_res_t      res
);
  import oal_pkg::*;

  // Signed greater-than, equality and sum modulo two to the word width.
  always_comb begin
    res.gt  = req.a > req.b;
    res.eq  = req.a == req.b;
    res.sum = req.a + req.b;
  end

endmodule

`default_nettype wire

@@ sv/oal_seq.sv @@
// ----------------------------------------------------------------------------
// Ordered array list sequencer
// Checks each command, walks the store one read per cycle through the shared
// unit, moves words for insert and delete, and holds the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oal_seq #(
  parameter int DEPTH = oal_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [oal_pkg::CNT_W-1:0]  capacity,
  oal_cmd_if.sink                         in_cmd,
  oal_rsp_if.source                       out_rsp,
  output logic                            mem_we,
  output logic      [AW-1:0]              mem_waddr,
  output logic      [oal_pkg::WORD_W-1:0] mem_wdata,
  output logic                            mem_re,
  output logic      [AW-1:0]              mem_raddr,
  input  wire logic [oal_pkg::WORD_W-1:0] mem_rdata,
  output oal_pkg::unit_req_t              unit_req,
  input  wire oal_pkg::unit_res_t         unit_res
);
  import oal_pkg::*;

  // The count never exceeds the smaller of the store depth and the largest
  // value the capacity register can hold.
  localparam int               LIM_INT = (DEPTH > (1 << CNT_W) - 1) ?
                                         (1 << CNT_W) - 1 : DEPTH;
  localparam logic [CNT_W-1:0] LIM_MAX = CNT_W'(LIM_INT);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_WALK  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  op_t                      op_r;
  logic [CNT_W-1:0]         pos_r;
  logic signed [WORD_W-1:0] val_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  status_t                  st_r, st_nxt;
  logic signed [WORD_W-1:0] res_r, res_nxt;
  logic [CNT_W-1:0]         rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]         rd_left_r, rd_left_nxt;
  logic                     pend_r, pend_nxt;
  logic [CNT_W-1:0]         pend_idx_r;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_st_r;
  logic signed [WORD_W-1:0] out_res_r;
  logic [CNT_W-1:0]         out_cnt_r;

  logic                     cmd_xfer;
  logic                     out_load;
  logic [CNT_W-1:0]         lim;
  logic                     full;
  logic                     walk_down;
  logic                     issue;
  logic signed [WORD_W-1:0] word;

  assign cmd_xfer  = in_cmd.valid && in_cmd.ready;
  assign lim       = (capacity > LIM_MAX) ? LIM_MAX : capacity;
  assign full      = count_r >= lim;
  assign walk_down = (op_r == OP_INSERT) || (op_r == OP_SORTED);
  assign issue     = (state_r == S_WALK) && (rd_left_r != '0);
  assign word      = mem_rdata;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_rsp.ready);

  // A new command is taken whenever no other one is in progress.
  assign in_cmd.ready = (state_r == S_IDLE);

  // Operand selection for the shared unit.
  always_comb begin
    unit_req.a = word;
    unit_req.b = val_r;
    case (op_r)
      OP_MAX: begin
        unit_req.a = word;
        unit_req.b = res_r;
      end
      OP_MIN: begin
        unit_req.a = res_r;
        unit_req.b = word;
      end
      OP_SUM: begin
        unit_req.a = res_r;
        unit_req.b = word;
      end
      default: begin
        unit_req.a = word;
        unit_req.b = val_r;
      end
    endcase
  end

  // Read side of the walk: one store read per cycle over the chosen range.
  always_comb begin
    mem_re      = issue;
    mem_raddr   = AW'(rd_idx_r);
    pend_nxt    = issue;
    rd_left_nxt = rd_left_r;
    rd_idx_nxt  = rd_idx_r;
    if (issue) begin
      rd_left_nxt = rd_left_r - 1'b1;
      rd_idx_nxt  = walk_down ? rd_idx_r - 1'b1 : rd_idx_r + 1'b1;
    end
    if (state_r == S_CHECK) begin
      pend_nxt    = 1'b0;
      rd_idx_nxt  = '0;
      rd_left_nxt = count_r;
      unique case (op_r)
        OP_INSERT: begin
          rd_idx_nxt  = count_r - 1'b1;
          rd_left_nxt = count_r - pos_r;
        end
        OP_SORTED: begin
          rd_idx_nxt  = count_r - 1'b1;
          rd_left_nxt = count_r;
        end
        OP_DELETE: begin
          rd_idx_nxt  = pos_r;
          rd_left_nxt = count_r - pos_r;
        end
        OP_GET: begin
          rd_idx_nxt  = pos_r;
          rd_left_nxt = CNT_W'(1);
        end
        default: begin
          rd_idx_nxt  = '0;
          rd_left_nxt = count_r;
        end
      endcase
    end
  end

  // Command checks, word moves and the end of each command.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    st_nxt    = st_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = AW'(count_r);
    mem_wdata = val_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_xfer) begin
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        st_nxt    = ST_OK;
        res_nxt   = '0;
        state_nxt = S_DONE;
        unique case (op_r)
          OP_APPEND: begin
            if (full) begin
              st_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = AW'(count_r);
              count_nxt = count_r + 1'b1;
            end
          end
          OP_INSERT: begin
            if (pos_r > count_r) begin
              st_nxt = ST_BADIDX;
            end else if (full) begin
              st_nxt = ST_FULL;
            end else begin
              state_nxt = S_WALK;
            end
          end
          OP_DELETE, OP_GET, OP_SET: begin
            if (count_r == '0) begin
              st_nxt = ST_EMPTY;
            end else if (pos_r >= count_r) begin
              st_nxt = ST_BADIDX;
            end else if (op_r == OP_SET) begin
              mem_we    = 1'b1;
              mem_waddr = AW'(pos_r);
            end else begin
              state_nxt = S_WALK;
            end
          end
          OP_SORTED: begin
            if (full) begin
              st_nxt = ST_FULL;
            end else begin
              state_nxt = S_WALK;
            end
          end
          OP_SEARCH, OP_MAX, OP_MIN: begin
            if (count_r == '0) begin
              st_nxt = ST_EMPTY;
            end else begin
              state_nxt = S_WALK;
            end
          end
          OP_SUM: begin
            state_nxt = S_WALK;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_WALK: begin
        if (pend_r) begin
          // A word read in the previous cycle is back from the store.
          unique case (op_r)
            OP_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = AW'(pend_idx_r + 1'b1);
              mem_wdata = word;
            end
            OP_SORTED: begin
              mem_we    = 1'b1;
              mem_waddr = AW'(pend_idx_r + 1'b1);
              if (unit_res.gt) begin
                mem_wdata = word;
              end else begin
                mem_wdata = val_r;
                count_nxt = count_r + 1'b1;
                state_nxt = S_DONE;
              end
            end
            OP_DELETE: begin
              if (pend_idx_r == pos_r) begin
                res_nxt = word;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(pend_idx_r - 1'b1);
                mem_wdata = word;
              end
            end
            OP_GET: begin
              res_nxt   = word;
              state_nxt = S_DONE;
            end
            OP_SEARCH: begin
              if (unit_res.eq) begin
                res_nxt   = WORD_W'(pend_idx_r);
                state_nxt = S_DONE;
              end
            end
            OP_MAX, OP_MIN: begin
              if ((pend_idx_r == '0) || unit_res.gt) begin
                res_nxt = word;
              end
            end
            OP_SUM: begin
              res_nxt = unit_res.sum;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end else if (!issue) begin
          // The range is exhausted with nothing in flight.
          state_nxt = S_DONE;
          unique case (op_r)
            OP_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = AW'(pos_r);
              count_nxt = count_r + 1'b1;
            end
            OP_SORTED: begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              count_nxt = count_r + 1'b1;
            end
            OP_DELETE: begin
              count_nxt = count_r - 1'b1;
            end
            OP_SEARCH: begin
              st_nxt  = ST_NOTFOUND;
              res_nxt = '0;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Response register: holds a result until the sink takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_st_r;
  assign out_rsp.result_word   = out_res_r;
  assign out_rsp.element_count = out_cnt_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Command, walk and result payload.
  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      op_r  <= op_t'(in_cmd.opcode);
      pos_r <= in_cmd.position;
      val_r <= in_cmd.operand_value;
    end
    st_r       <= st_nxt;
    res_r      <= res_nxt;
    rd_idx_r   <= rd_idx_nxt;
    rd_left_r  <= rd_left_nxt;
    pend_idx_r <= rd_idx_r;
    if (out_load) begin
      out_st_r  <= st_r;
      out_res_r <= res_r;
      out_cnt_r <= count_r;
    end
  end

endmodule

`default_nettype wire

@@ sv/ordered_array_list_engine.sv @@
// ----------------------------------------------------------------------------
// Ordered array list engine
// Bounded list of signed words with append, insert, delete, get, set, sorted
// insert, search, max, min and sum, one response per command.
// ----------------------------------------------------------------------------
// One command at a time: a command is taken when the engine is idle and its
// response comes out of a register that may wait for the sink while the next
// command is already taken. Append, set, unknown opcodes and every rejected
// command go from the check state straight to the done state and its response
// register. Commands that visit stored words walk the store through its single
// read port, one word per cycle, over k words (count - position for insert and
// delete, one for get, up to count for sorted insert and search, count for max,
// min and sum), so never more than DEPTH words.
// The store needs no clearing after reset; only written entries are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ordered_array_list_engine #(
  parameter int DEPTH = oal_pkg::DEPTH_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [oal_pkg::CNT_W-1:0] cfg_wdata,
  oal_cmd_if.sink                        in_cmd,
  oal_rsp_if.source                      out_rsp
);
  import oal_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [CNT_W-1:0]  capacity_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;
  unit_req_t         unit_req;
  unit_res_t         unit_res;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_r <= cfg_wdata;
    end
  end

  // Command sequencer.
  oal_seq #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .capacity  (capacity_r),
    .in_cmd    (in_cmd),
    .out_rsp   (out_rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .unit_req  (unit_req),
    .unit_res  (unit_res)
  );

  // Element store.
  oal_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Shared compare and add unit.
  oal_unit u_unit (
    .req (unit_req),
    .res (unit_res)
  );

endmodule

`default_nettype wire
